### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pharmacode encoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(LBL, CLK, RSTN, COND) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (COND)) \
        else $error("assertion failed: %m");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("assertion failed: %m");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("assertion failed: %m");

`endif

### rtl/tpe_pkg.sv
// ----------------------------------------------------------------------------
// Pharmacode encoder package
// Types and fixed constants shared by the two-track pharmacode encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tpe_pkg;

    // Field widths fixed by the item format.
    localparam int VALUE_W = 27;
    localparam int POS_W   = 4;
    localparam int DIGIT_W = 2;

    // Accepted value range: the top end is sixteen digits of three.
    localparam logic [VALUE_W-1:0] VALUE_MIN = 27'd4;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 27'd64570080;

    // Reciprocal of three: floor(v / 3) = (v * RECIP3) >> RECIP3_SHIFT.
    localparam logic [31:0] RECIP3       = 32'hAAAA_AAAB;
    localparam int          RECIP3_SHIFT = 33;

    // Bijective base-3 digit codes.
    localparam logic [DIGIT_W-1:0] DIGIT_ONE   = 2'd1;
    localparam logic [DIGIT_W-1:0] DIGIT_TWO   = 2'd2;
    localparam logic [DIGIT_W-1:0] DIGIT_THREE = 2'd3;

    // Result status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT,
        ST_ERROR
    } seq_state_t;

    // One result item as it travels from the sequencer to the output stage.
    typedef struct packed {
        logic             status;
        logic             top_bar;
        logic             bottom_bar;
        logic [POS_W-1:0] bar_position;
        logic             last;
    } bar_item_t;

endpackage

`default_nettype wire

### rtl/tpe_div3.sv
// ----------------------------------------------------------------------------
// Divide-by-three step unit
// Takes one bijective base-3 digit off a value and returns the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module tpe_div3 (
    input  wire logic [tpe_pkg::VALUE_W-1:0] operand,
    output logic      [tpe_pkg::DIGIT_W-1:0] digit,
    output logic      [tpe_pkg::VALUE_W-1:0] quotient
);
    import tpe_pkg::*;

    logic [59:0]        prod;
    logic [VALUE_W-1:0] q_floor;
    logic [VALUE_W+1:0] q_times3;
    logic [VALUE_W+1:0] diff;
    logic [1:0]         rem;

    // Floor division by three through the reciprocal.
    always_comb
    begin
        prod    = 60'(operand) * 60'(RECIP3);
        q_floor = prod[RECIP3_SHIFT +: VALUE_W];
    end

    // Remainder, then digit in 1..3 and the quotient (operand - digit) / 3.
    always_comb
    begin
        q_times3 = {2'b00, q_floor} + {1'b0, q_floor, 1'b0};
        diff     = {2'b00, operand} - q_times3;
        rem      = diff[1:0];
        if (rem == 2'd0)
        begin
            digit    = DIGIT_THREE;
            quotient = q_floor - VALUE_W'(1);
        end
        else
        begin
            digit    = rem;
            quotient = q_floor;
        end
    end

endmodule

`default_nettype wire

### rtl/tpe_seq.sv
// ----------------------------------------------------------------------------
// Pharmacode sequencer
// Range check, digit loop over the shared divide unit, and bar emission.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tpe_seq #(
    parameter int MAX_BARS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [tpe_pkg::VALUE_W-1:0] value,
    output logic                             in_ready,
    output logic      [tpe_pkg::VALUE_W-1:0] div_operand,
    input  wire logic [tpe_pkg::DIGIT_W-1:0] div_digit,
    input  wire logic [tpe_pkg::VALUE_W-1:0] div_quotient,
    input  wire logic                        out_free,
    output logic                             out_load,
    output tpe_pkg::bar_item_t               out_item
);
    import tpe_pkg::*;

    localparam int IDX_W = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
    localparam int CNT_W = $clog2(MAX_BARS + 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BARS);

    seq_state_t         state_reg, state_next;
    logic [VALUE_W-1:0] work_reg, work_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   emit_reg, emit_next;

    // Digits, least significant first; each entry is written before it is read.
    logic [DIGIT_W-1:0] digit_mem [MAX_BARS];

    logic               in_range;
    logic               work_zero;
    logic               div_en;
    logic               emit_last;
    logic [CNT_W-1:0]   rd_pos;
    logic [DIGIT_W-1:0] rd_digit;

    // Status terms.
    always_comb
    begin
        in_range  = (value >= VALUE_MIN) && (value <= VALUE_MAX);
        work_zero = (work_reg == '0);
        emit_last = (emit_reg == cnt_reg - CNT_ONE);
        rd_pos    = cnt_reg - CNT_ONE - emit_reg;
        rd_digit  = digit_mem[rd_pos[IDX_W-1:0]];
    end

    assign div_operand = work_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_range ? ST_DIVIDE : ST_ERROR;
                end
            end
            ST_DIVIDE:
            begin
                if (!div_en)
                begin
                    state_next = work_zero ? ST_EMIT : ST_ERROR;
                end
            end
            ST_EMIT:
            begin
                if (out_free && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERROR:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready              = 1'b0;
        div_en                = 1'b0;
        out_load              = 1'b0;
        out_item.status       = STATUS_OK;
        out_item.top_bar      = 1'b0;
        out_item.bottom_bar   = 1'b0;
        out_item.bar_position = '0;
        out_item.last         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_DIVIDE:
            begin
                div_en = !work_zero && (cnt_reg < CNT_MAX);
            end
            ST_EMIT:
            begin
                out_load              = out_free;
                out_item.top_bar      = (rd_digit == DIGIT_TWO) || (rd_digit == DIGIT_THREE);
                out_item.bottom_bar   = (rd_digit == DIGIT_ONE) || (rd_digit == DIGIT_THREE);
                out_item.bar_position = POS_W'(emit_reg);
                out_item.last         = emit_last;
            end
            ST_ERROR:
            begin
                out_load        = out_free;
                out_item.status = STATUS_RANGE;
                out_item.last   = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Working value and counters.
    always_comb
    begin
        work_next = work_reg;
        cnt_next  = cnt_reg;
        emit_next = emit_reg;
        if (in_ready && in_valid)
        begin
            work_next = value;
            cnt_next  = '0;
            emit_next = '0;
        end
        else if (div_en)
        begin
            work_next = div_quotient;
            cnt_next  = cnt_reg + CNT_ONE;
        end
        else if (out_load && (state_reg == ST_EMIT))
        begin
            emit_next = emit_reg + CNT_ONE;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            work_reg  <= '0;
            cnt_reg   <= '0;
            emit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            work_reg  <= work_next;
            cnt_reg   <= cnt_next;
            emit_reg  <= emit_next;
        end
    end

    // Digit store write.
    always_ff @(posedge clk)
    begin
        if (div_en)
        begin
            digit_mem[cnt_reg[IDX_W-1:0]] <= div_digit;
        end
    end

    `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_MAX)
    `ASSERT_IMPLIES(a_emit_clean, clk, rst_n, state_reg == ST_EMIT,
                    work_zero && (cnt_reg != '0) && (emit_reg < cnt_reg))
    `ASSERT_NEXT(a_last_idle, clk, rst_n, out_load && out_item.last, state_reg == ST_IDLE)
    `ASSERT_IMPLIES(a_ok_status, clk, rst_n, out_load && (state_reg == ST_EMIT),
                    out_item.status == STATUS_OK)

endmodule

`default_nettype wire

### rtl/tpe_out.sv
// ----------------------------------------------------------------------------
// Pharmacode output stage
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tpe_out (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire tpe_pkg::bar_item_t item_in,
    output logic              free,
    output logic              out_valid,
    input  wire logic         out_ready,
    output tpe_pkg::bar_item_t item_out
);
    import tpe_pkg::*;

    logic      valid_reg, valid_next;
    bar_item_t item_reg;

    // The slot may take a new item when empty or being emptied this cycle.
    always_comb
    begin
        free       = !valid_reg || out_ready;
        valid_next = load || (valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign out_valid = valid_reg;
    assign item_out  = item_reg;

endmodule

`default_nettype wire

### rtl/two_track_pharmacode_encoder.sv
// ----------------------------------------------------------------------------
// Two-track pharmacode encoder
// Turns an integer into top/bottom track bars, most significant bar first.
// ----------------------------------------------------------------------------
// One value is taken per run. A value in 4..64570080 is written in bijective
// base 3, one digit per clock through a single divide-by-three unit; after
// acceptance the sequencer runs the digit loop (up to 16 digits), then a
// check, then emits one bar item per cycle while the output side is ready. A
// value out of range gives a single error item, loaded into the output
// register once it is free; a value that needs more than MAX_BARS bars gives
// the same error item after the digit loop. The input is not ready until the
// last item of a run has been loaded into the output register.
`default_nettype none

module two_track_pharmacode_encoder #(
    parameter int MAX_BARS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [26:0] value, [31:27] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,  // [0] top_bar, [1] bottom_bar,
                                            // [5:2] bar_position, [7:6] zero
    output logic             m_axis_tlast,
    output logic             m_axis_tuser   // [0] status
);
    import tpe_pkg::*;

    logic               out_free;
    logic               out_load;
    bar_item_t          seq_item;
    bar_item_t          out_item;
    logic [VALUE_W-1:0] div_operand;
    logic [DIGIT_W-1:0] div_digit;
    logic [VALUE_W-1:0] div_quotient;

    // Shared divide-by-three unit.
    tpe_div3 u_div3 (
        .operand  (div_operand),
        .digit    (div_digit),
        .quotient (div_quotient)
    );

    // Sequencer with digit store.
    tpe_seq #(
        .MAX_BARS (MAX_BARS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .value        (s_axis_tdata[VALUE_W-1:0]),
        .in_ready     (s_axis_tready),
        .div_operand  (div_operand),
        .div_digit    (div_digit),
        .div_quotient (div_quotient),
        .out_free     (out_free),
        .out_load     (out_load),
        .out_item     (seq_item)
    );

    // Output register.
    tpe_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .item_in   (seq_item),
        .free      (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .item_out  (out_item)
    );

    // Pack the result item onto the stream.
    assign m_axis_tdata = {2'b00, out_item.bar_position, out_item.bottom_bar, out_item.top_bar};
    assign m_axis_tlast = out_item.last;
    assign m_axis_tuser = out_item.status;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Two-track pharmacode encoder testbench
// Streams integers into the encoder and checks every bar item it returns.
// ----------------------------------------------------------------------------
// A short table of directed values comes first. It covers the range limits,
// the field extremes and codes made of a single digit kind. Random values
// follow, built mostly from random base-3 digit strings of every length, so
// every bar count from two to sixteen occurs. Both sides of the stream idle
// at random in the first two phases and never in the third. Each returned
// item is compared with the oldest bar that the bench predicted.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpe_pkg::*;

    localparam int BAR_LIMIT        = 16;
    localparam int STALL_LIMIT      = 5000;
    localparam int DRAIN_CYCLES     = 40;
    localparam int RANDOM_PER_PHASE = 80;
    localparam int SHOWN_FAULTS     = 10;

    // Largest value the bench offers; everything above VALUE_MAX up to here is an error.
    localparam logic [VALUE_W-1:0] FIELD_TOP = 27'd99999999;

    // How a directed row is checked: by the local encoder, as a range error,
    // or as a code whose bars all carry the same digit.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_RANGE,
        CHK_UNIFORM
    } row_check_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        row_check_t         check;
        logic [DIGIT_W-1:0] digit;
        logic [4:0]         bars;
    } stim_row_t;

    stim_row_t directed_rows [0:21] = '{
        '{27'd0,        CHK_RANGE,   DIGIT_ONE,   5'd0},
        '{27'd1,        CHK_RANGE,   DIGIT_ONE,   5'd0},
        '{27'd2,        CHK_RANGE,   DIGIT_ONE,   5'd0},
        '{27'd3,        CHK_RANGE,   DIGIT_ONE,   5'd0},
        '{27'd4,        CHK_UNIFORM, DIGIT_ONE,   5'd2},
        '{27'd5,        CHK_MODEL,   DIGIT_ONE,   5'd0},
        '{27'd6,        CHK_MODEL,   DIGIT_ONE,   5'd0},
        '{27'd8,        CHK_UNIFORM, DIGIT_TWO,   5'd2},
        '{27'd12,       CHK_UNIFORM, DIGIT_THREE, 5'd2},
        '{27'd13,       CHK_UNIFORM, DIGIT_ONE,   5'd3},
        '{27'd39,       CHK_UNIFORM, DIGIT_THREE, 5'd3},
        '{27'd21523359, CHK_UNIFORM, DIGIT_THREE, 5'd15},
        '{27'd21523360, CHK_UNIFORM, DIGIT_ONE,   5'd16},
        '{27'd21523361, CHK_MODEL,   DIGIT_ONE,   5'd0},
        '{27'd43046720, CHK_UNIFORM, DIGIT_TWO,   5'd16},
        '{27'd44739242, CHK_MODEL,   DIGIT_ONE,   5'd0},
        '{27'd64570079, CHK_MODEL,   DIGIT_ONE,   5'd0},
        '{VALUE_MAX,    CHK_UNIFORM, DIGIT_THREE, 5'd16},
        '{27'd64570081, CHK_RANGE,   DIGIT_ONE,   5'd0},
        '{27'd67108864, CHK_RANGE,   DIGIT_ONE,   5'd0},
        '{27'd89478485, CHK_RANGE,   DIGIT_ONE,   5'd0},
        '{FIELD_TOP,    CHK_RANGE,   DIGIT_ONE,   5'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [26:0] value, [31:27] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [0] top_bar, [1] bottom_bar, [5:2] bar_position
    logic        m_axis_tlast;
    logic        m_axis_tuser;   // [0] status

    bar_item_t   pending_bars [$];
    bar_item_t   bar_seen;
    bar_item_t   bar_due;
    int          fault_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          stall_cycles;

    two_track_pharmacode_encoder #(
        .MAX_BARS (BAR_LIMIT)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    // The single item given for any value that cannot be encoded.
    function automatic bar_item_t range_error_item();
        bar_item_t bar;
        bar.status       = STATUS_RANGE;
        bar.top_bar      = 1'b0;
        bar.bottom_bar   = 1'b0;
        bar.bar_position = '0;
        bar.last         = 1'b1;
        return bar;
    endfunction

    // Writes the value in bijective base 3 and queues one bar per digit,
    // most significant digit first.
    function automatic void encode_value(input logic [VALUE_W-1:0] value);
        logic [DIGIT_W-1:0] digits [16];
        logic [DIGIT_W-1:0] d;
        logic [31:0]        rest;
        int                 count;
        bar_item_t          bar;
        if (value < VALUE_MIN || value > VALUE_MAX) begin
            pending_bars.push_back(range_error_item());
            return;
        end
        rest  = value;
        count = 0;
        while (rest != 0 && count < BAR_LIMIT) begin
            case (rest % 3)
                0:       d = DIGIT_THREE;
                1:       d = DIGIT_ONE;
                default: d = DIGIT_TWO;
            endcase
            digits[count] = d;
            count         = count + 1;
            rest          = (rest - d) / 3;
        end
        // A code longer than the bar limit is refused as out of range.
        if (rest != 0) begin
            pending_bars.push_back(range_error_item());
            return;
        end
        for (int k = 0; k < count; k++) begin
            d                = digits[count - 1 - k];
            bar.status       = STATUS_OK;
            bar.top_bar      = (d == DIGIT_TWO || d == DIGIT_THREE);
            bar.bottom_bar   = (d == DIGIT_ONE || d == DIGIT_THREE);
            bar.bar_position = k[POS_W-1:0];
            bar.last         = (k == count - 1);
            pending_bars.push_back(bar);
        end
    endfunction

    // Offers one value, after a random gap, and queues its bars once accepted.
    task automatic offer_value(input logic [VALUE_W-1:0] value, input row_check_t check,
                               input logic [DIGIT_W-1:0] digit, input int bars);
        bar_item_t bar;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(32 - VALUE_W){1'b0}}, value};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        case (check)
            CHK_RANGE:
                pending_bars.push_back(range_error_item());
            CHK_UNIFORM:
                for (int k = 0; k < bars; k++) begin
                    bar.status       = STATUS_OK;
                    bar.top_bar      = (digit != DIGIT_ONE);
                    bar.bottom_bar   = (digit != DIGIT_TWO);
                    bar.bar_position = k[POS_W-1:0];
                    bar.last         = (k == bars - 1);
                    pending_bars.push_back(bar);
                end
            default:
                encode_value(value);
        endcase
    endtask

    // Output side: check each item taken, then choose the next ready level.
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            bar_seen.status       = m_axis_tuser;
            bar_seen.top_bar      = m_axis_tdata[0];
            bar_seen.bottom_bar   = m_axis_tdata[1];
            bar_seen.bar_position = m_axis_tdata[5:2];
            bar_seen.last         = m_axis_tlast;
            if (pending_bars.size() == 0) begin
                if (fault_count < SHOWN_FAULTS)
                    $display("%0t: unexpected item status=%0d top=%0d bottom=%0d pos=%0d last=%0d",
                             $time, bar_seen.status, bar_seen.top_bar, bar_seen.bottom_bar,
                             bar_seen.bar_position, bar_seen.last);
                fault_count = fault_count + 1;
            end
            else begin
                bar_due = pending_bars.pop_front();
                if (bar_seen.status != bar_due.status || bar_seen.top_bar != bar_due.top_bar ||
                    bar_seen.bottom_bar != bar_due.bottom_bar ||
                    bar_seen.bar_position != bar_due.bar_position ||
                    bar_seen.last != bar_due.last) begin
                    if (fault_count < SHOWN_FAULTS)
                        $display("%0t: bar mismatch, expected status=%0d top=%0d bottom=%0d ",
                                 $time, bar_due.status, bar_due.top_bar, bar_due.bottom_bar,
                                 "pos=%0d last=%0d, got status=%0d ",
                                 bar_due.bar_position, bar_due.last, bar_seen.status,
                                 "top=%0d bottom=%0d pos=%0d last=%0d",
                                 bar_seen.top_bar, bar_seen.bottom_bar, bar_seen.bar_position,
                                 bar_seen.last);
                    fault_count = fault_count + 1;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Cycles since the last item moved on either side.
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // A correct run never pauses for more than a digit pass plus a long stall.
    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no item moved for %0d cycles, %0d bars outstanding",
                 $time, STALL_LIMIT, pending_bars.size());
        $display("[two_track_pharmacode_encoder] ERROR");
        $finish;
    end

    // Stimulus: reset, the directed table, then three phases of random values.
    initial begin
        logic [31:0] value;
        int unsigned pick;
        int unsigned length;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        fault_count   = 0;
        stall_cycles  = 0;
        send_idle_pct = 27;
        recv_idle_pct = 58;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_value(directed_rows[i].value, directed_rows[i].check,
                        directed_rows[i].digit, directed_rows[i].bars);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 58 : 0;
            recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 27 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                if (pick < 85) begin
                    // A random digit string of random length gives a valid code.
                    length = $urandom_range(2, BAR_LIMIT);
                    value  = 0;
                    for (int k = 0; k < length; k++)
                        value = value * 3 + $urandom_range(1, 3);
                end
                else if (pick < 89)
                    value = $urandom_range(VALUE_MIN - 1);
                else if (pick < 93)
                    value = $urandom_range(FIELD_TOP, VALUE_MAX + 1);
                else
                    value = $urandom_range(FIELD_TOP);
                offer_value(value[VALUE_W-1:0], CHK_MODEL, DIGIT_ONE, 0);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Error items follow acceptance and bars follow a digit pass, so a short
        // drain catches anything extra.
        while (pending_bars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("[two_track_pharmacode_encoder] OK");
        else
            $display("[two_track_pharmacode_encoder] ERROR");
        $finish;
    end

endmodule
